### rtl/core/swm_pkg.sv
// ============================================================================
// Sliding window median package
// Shared sizes, sorted-cell entry type, control bundle and window clamp.
// ============================================================================
`timescale 1ns / 1ps

package swm_pkg;

  // Storage and field sizes.
  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 32;
  localparam int CFG_W       = 7;
  localparam int CNT_W       = $clog2(WINDOW_MAX + 1);
  localparam int AGE_W       = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int MID_NUM     = (WINDOW_MAX + 1) / 2;
  localparam int MID_W       = (MID_NUM > 1) ? $clog2(MID_NUM) : 1;

  // Window size after reset.
  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(3);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One sorted cell: the sample and how many items ago it arrived.
  typedef struct packed {
    sample_t          val;
    logic [AGE_W-1:0] age;
  } swm_entry_t;

  // Control bundle from the top level to the cell array.
  typedef struct packed {
    logic             upd;
    logic             full;
    logic [CNT_W-1:0] fill;
    logic [AGE_W-1:0] oldest_age;
  } swm_ctl_t;

  // Clamp the programmed window size into 1..WINDOW_MAX.
  function automatic logic [CNT_W-1:0] eff_window(input logic [CFG_W-1:0] cfg);
    logic [CNT_W-1:0] w;
    if (cfg == '0) begin
      w = CNT_W'(1);
    end else if (int'(cfg) > WINDOW_MAX) begin
      w = CNT_W'(WINDOW_MAX);
    end else begin
      w = CNT_W'(cfg);
    end
    return w;
  endfunction

endpackage

### rtl/core/swm_cell.sv
// ============================================================================
// Sorted window cell
// Holds one entry of the sorted window and picks its next content from its
// neighbors, itself or the new sample in a single update.
// ============================================================================
`timescale 1ns / 1ps

module swm_cell (
  input  logic               clk,
  input  swm_pkg::swm_ctl_t  ctl_i,
  input  swm_pkg::sample_t   key_i,
  input  logic               vld_i,
  input  swm_pkg::swm_entry_t prev_i,
  input  swm_pkg::swm_entry_t next_i,
  input  logic               rb_i,
  input  logic               rb_prev_i,
  input  logic               bl_i,
  input  logic               bl_prev_i,
  output swm_pkg::swm_entry_t ent_o,
  output swm_pkg::swm_entry_t nxt_o,
  output logic               le_o,
  output logic               rm_o
);
  import swm_pkg::*;

  swm_entry_t ent_r;
  swm_entry_t ent_nxt;
  swm_entry_t b_self;
  swm_entry_t b_prev;

  // Compare against the new sample and flag this cell as the oldest one.
  assign le_o = vld_i && (ent_r.val <= key_i);
  assign rm_o = vld_i && ctl_i.full && (ent_r.age == ctl_i.oldest_age);

  // Next content: the list after removal, shifted around the insert point.
  always_comb begin
    b_self = rb_i ? next_i : ent_r;
    b_prev = rb_prev_i ? ent_r : prev_i;
    if (bl_i) begin
      ent_nxt.val = b_self.val;
      ent_nxt.age = b_self.age + AGE_W'(1);
    end else if (bl_prev_i) begin
      ent_nxt.val = key_i;
      ent_nxt.age = '0;
    end else begin
      ent_nxt.val = b_prev.val;
      ent_nxt.age = b_prev.age + AGE_W'(1);
    end
  end

  // Cell storage, loaded once per processed item.
  always_ff @(posedge clk) begin
    if (ctl_i.upd) begin
      ent_r <= ent_nxt;
    end
  end

  assign ent_o = ent_r;
  assign nxt_o = ent_nxt;

endmodule

### rtl/core/swm_window.sv
// ============================================================================
// Sorted window array
// A row of sorted cells with the removal and insert position chains, and
// the selection of the median from the updated row.
// ============================================================================
`timescale 1ns / 1ps

module swm_window (
  input  logic                          clk,
  input  swm_pkg::swm_ctl_t             ctl_i,
  input  swm_pkg::sample_t              key_i,
  input  logic [swm_pkg::MID_W-1:0]     mid_i,
  output swm_pkg::sample_t              median_o,
  output logic [swm_pkg::WINDOW_MAX-1:0] rm_o
);
  import swm_pkg::*;

  swm_entry_t ent  [WINDOW_MAX];
  swm_entry_t nxt  [WINDOW_MAX];
  sample_t    mids [MID_NUM];
  logic [WINDOW_MAX:0]   le;
  logic [WINDOW_MAX-1:0] rb;
  logic [WINDOW_MAX-1:0] bl;
  logic [WINDOW_MAX-1:0] vld;

  // There is never a valid entry past the end of the row.
  assign le[WINDOW_MAX] = 1'b0;

  genvar j;
  generate
    for (j = 0; j < WINDOW_MAX; j++) begin : g_cell
      swm_entry_t prev_e;
      swm_entry_t next_e;
      logic       rb_prev;
      logic       bl_prev;

      // Entries below the fill count hold samples.
      assign vld[j] = (CNT_W'(j) < ctl_i.fill);

      // Removal at or below this cell, and entry of the reduced list <= key.
      if (j == 0) begin : g_first
        assign rb[j]   = rm_o[j];
        assign rb_prev = 1'b0;
        assign bl_prev = 1'b1;
        assign prev_e  = '0;
      end else begin : g_rest
        assign rb[j]   = rb[j-1] | rm_o[j];
        assign rb_prev = rb[j-1];
        assign bl_prev = bl[j-1];
        assign prev_e  = ent[j-1];
      end

      if (j == WINDOW_MAX - 1) begin : g_last
        assign next_e = '0;
      end else begin : g_inner
        assign next_e = ent[j+1];
      end

      assign bl[j] = rb[j] ? le[j+1] : le[j];

      swm_cell u_cell (
        .clk       (clk),
        .ctl_i     (ctl_i),
        .key_i     (key_i),
        .vld_i     (vld[j]),
        .prev_i    (prev_e),
        .next_i    (next_e),
        .rb_i      (rb[j]),
        .rb_prev_i (rb_prev),
        .bl_i      (bl[j]),
        .bl_prev_i (bl_prev),
        .ent_o     (ent[j]),
        .nxt_o     (nxt[j]),
        .le_o      (le[j]),
        .rm_o      (rm_o[j])
      );
    end

    // Only the lower half of the row can hold the median.
    for (j = 0; j < MID_NUM; j++) begin : g_mid
      assign mids[j] = nxt[j].val;
    end
  endgenerate

  assign median_o = mids[mid_i];

endmodule

### rtl/core/sliding_window_median.sv
// ============================================================================
// Sliding window median filter
// Keeps the most recent samples in a sorted row of cells and gives the
// lower median of the window once it has filled.
// ============================================================================
// An accepted item waits in the input register; its median is then held in the result register.
// Throughput: one item per cycle unless stalled; the whole sorted row updates at once.
// Stalls come only from a held result that out_ready has not taken.
// Reset and any write of the window size empty the window; reset sets size 3.
`timescale 1ns / 1ps

module sliding_window_median (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [swm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  swm_pkg::sample_t              in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output swm_pkg::sample_t              out_median
);
  import swm_pkg::*;

  logic [CFG_W-1:0] cfg_window_size_r;
  logic [CNT_W-1:0] fill_r;
  logic [CNT_W-1:0] fill_nxt;
  logic             s_vld_r;
  sample_t          s_sample_r;
  logic             out_valid_r;
  sample_t          out_median_r;

  logic [CNT_W-1:0]      win;
  logic                  full;
  logic                  emit;
  logic                  fire;
  swm_ctl_t              ctl;
  sample_t               median;
  logic [WINDOW_MAX-1:0] rm_vec;
  logic [MID_W-1:0]      mid;

  // Window bookkeeping.
  assign win  = eff_window(cfg_window_size_r);
  assign full = (fill_r >= win);
  assign emit = full || ((fill_r + CNT_W'(1)) == win);
  assign mid  = MID_W'((win - CNT_W'(1)) >> 1);
  assign fill_nxt = full ? fill_r : (fill_r + CNT_W'(1));

  // The held item is processed unless its result would overwrite a waiting one.
  assign fire     = s_vld_r && (!emit || !out_valid_r || out_ready);
  assign in_ready = !s_vld_r || fire;

  assign ctl.upd        = fire;
  assign ctl.full       = full;
  assign ctl.fill       = fill_r;
  assign ctl.oldest_age = AGE_W'(win - CNT_W'(1));

  swm_window u_window (
    .clk      (clk),
    .ctl_i    (ctl),
    .key_i    (s_sample_r),
    .mid_i    (mid),
    .median_o (median),
    .rm_o     (rm_vec)
  );

  // Configuration register and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_window_size_r <= CFG_RESET;
      fill_r            <= '0;
    end else if (cfg_we) begin
      cfg_window_size_r <= cfg_wdata;
      fill_r            <= '0;
    end else if (fire) begin
      fill_r <= fill_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_vld_r <= 1'b1;
    end else if (fire) begin
      s_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_sample_r <= in_sample;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_median_r <= median;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_median = out_median_r;

  // The fill count never runs past the window.
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win)
    else $error("fill count exceeds window size");

  // A full window always has exactly one oldest entry to drop.
  a_one_oldest: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && full) |-> $onehot(rm_vec))
    else $error("oldest entry not unique");

  // A size write restarts the window from empty.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (fill_r == '0))
    else $error("window not emptied after size write");

endmodule
